>>> rtl/ffha_pkg.sv
// ============================================================================
// ffha_pkg
// Shared constants, datapath opcodes and status type for the first-fit heap
// allocator.
// ============================================================================
package ffha_pkg;

    localparam int ARENA_BYTES_DEF   = 4096;
    localparam int GRANULE_BYTES_DEF = 16;

    // fixed port widths
    localparam int ADDR_W = 12;
    localparam int SIZE_W = 16;
    localparam int OFFS_W = 12;

    // controller -> datapath command
    typedef logic [3:0] dp_op_t;

    localparam dp_op_t OP_NONE     = 4'd0;
    localparam dp_op_t OP_ACCEPT   = 4'd1;
    localparam dp_op_t OP_A_START  = 4'd2;
    localparam dp_op_t OP_A_EVAL   = 4'd3;
    localparam dp_op_t OP_A_WRHDR  = 4'd4;
    localparam dp_op_t OP_F_READ   = 4'd5;
    localparam dp_op_t OP_F_MARK   = 4'd6;
    localparam dp_op_t OP_M_START  = 4'd7;
    localparam dp_op_t OP_M_LOAD   = 4'd8;
    localparam dp_op_t OP_M_EVAL   = 4'd9;
    localparam dp_op_t OP_OUT_LOAD = 4'd10;

    // datapath -> controller status
    typedef struct packed {
        logic fit;       // current header is free and large enough
        logic at_end;    // walk has no further block
        logic off_zero;  // free request with null offset
        logic g_ok;      // freed granule maps to a header inside the arena
    } dp_stat_t;

endpackage

>>> rtl/first_fit_heap_allocator_unit.sv
// ============================================================================
// first_fit_heap_allocator_unit
// First-fit allocator over an arena kept as an implicit list of block headers.
// One word in gives one word out. Allocate walks the headers from the start,
// one header per cycle out of the header memory, and takes the first free
// block that fits, splitting off the rest when two or more granules are left.
// Free marks the block, then one merge pass walks the whole list, again one
// header per cycle, joining adjacent free blocks. Every block holds at least
// one payload granule, so the list holds at most half as many blocks as there
// are granules (128 at the default size). The header memory's single read
// port sets the pace of both walks. A finished result waits in an output
// register, so the next word is accepted while it is still pending. Freed
// offsets are only range-checked: one outside the arena skips the mark but
// still runs the merge pass; freeing offset 0 does nothing.
// ============================================================================
module first_fit_heap_allocator_unit
#(
    parameter int ARENA_BYTES   = ffha_pkg::ARENA_BYTES_DEF,
    parameter int GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic [ffha_pkg::SIZE_W-1:0] request_size,
    input  logic [ffha_pkg::OFFS_W-1:0] payload_offset,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ffha_pkg::ADDR_W-1:0] address,
    output logic                        granted
);

    ffha_pkg::dp_op_t   op;
    ffha_pkg::dp_stat_t stat;

    ffha_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .op        (op)
    );

    ffha_datapath
    #(
        .ARENA_BYTES   (ARENA_BYTES),
        .GRANULE_BYTES (GRANULE_BYTES)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .action         (action),
        .request_size   (request_size),
        .payload_offset (payload_offset),
        .stat           (stat),
        .address        (address),
        .granted        (granted)
    );

endmodule

>>> rtl/ffha_ctrl.sv
// ============================================================================
// ffha_ctrl
// Sequencer for the allocator: accepts a word, steps the datapath through the
// first-fit walk or the mark-and-merge pass, and owns the output valid.
// ============================================================================
module ffha_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    output logic               out_valid,
    input  logic               out_ready,
    input  ffha_pkg::dp_stat_t stat,
    output ffha_pkg::dp_op_t   op
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_A_START = 4'd1;
    localparam logic [3:0] ST_A_EVAL  = 4'd2;
    localparam logic [3:0] ST_A_WRHDR = 4'd3;
    localparam logic [3:0] ST_F_CHK   = 4'd4;
    localparam logic [3:0] ST_F_MARK  = 4'd5;
    localparam logic [3:0] ST_M_START = 4'd6;
    localparam logic [3:0] ST_M_LOAD  = 4'd7;
    localparam logic [3:0] ST_M_EVAL  = 4'd8;
    localparam logic [3:0] ST_FIN     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op             = ffha_pkg::OP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = ffha_pkg::OP_ACCEPT;
                    state_next = action ? ST_F_CHK : ST_A_START;
                end
            end
            ST_A_START:
            begin
                op         = ffha_pkg::OP_A_START;
                state_next = ST_A_EVAL;
            end
            ST_A_EVAL:
            begin
                op = ffha_pkg::OP_A_EVAL;
                if (stat.fit)
                begin
                    state_next = ST_A_WRHDR;
                end
                else if (stat.at_end)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_A_WRHDR:
            begin
                op         = ffha_pkg::OP_A_WRHDR;
                state_next = ST_FIN;
            end
            ST_F_CHK:
            begin
                if (stat.off_zero)
                begin
                    state_next = ST_FIN;
                end
                else if (stat.g_ok)
                begin
                    op         = ffha_pkg::OP_F_READ;
                    state_next = ST_F_MARK;
                end
                else
                begin
                    state_next = ST_M_START;
                end
            end
            ST_F_MARK:
            begin
                op         = ffha_pkg::OP_F_MARK;
                state_next = ST_M_START;
            end
            ST_M_START:
            begin
                op         = ffha_pkg::OP_M_START;
                state_next = ST_M_LOAD;
            end
            ST_M_LOAD:
            begin
                op         = ffha_pkg::OP_M_LOAD;
                state_next = stat.at_end ? ST_FIN : ST_M_EVAL;
            end
            ST_M_EVAL:
            begin
                op = ffha_pkg::OP_M_EVAL;
                if (stat.at_end)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // result register free (or emptying now): load and go idle
                if (!out_valid_reg || out_ready)
                begin
                    op             = ffha_pkg::OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != ST_IDLE)
        else $error("accepted word did not start work");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && (!out_valid_reg || out_ready)
        |=> state_reg == ST_IDLE && out_valid_reg)
        else $error("finished result not loaded into output register");

endmodule

>>> rtl/ffha_datapath.sv
// ============================================================================
// ffha_datapath
// Header memory, walk registers, size-to-granule conversion and result
// registers. Every action is selected by the opcode from the sequencer.
// ============================================================================
module ffha_datapath
#(
    parameter int ARENA_BYTES   = ffha_pkg::ARENA_BYTES_DEF,
    parameter int GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffha_pkg::dp_op_t              op,
    input  logic                          action,
    input  logic [ffha_pkg::SIZE_W-1:0]   request_size,
    input  logic [ffha_pkg::OFFS_W-1:0]   payload_offset,
    output ffha_pkg::dp_stat_t            stat,
    output logic [ffha_pkg::ADDR_W-1:0]   address,
    output logic                          granted
);

    localparam int NGRAN    = ARENA_BYTES / GRANULE_BYTES;
    localparam int IDX_W    = $clog2(NGRAN);
    localparam int HDR_W    = IDX_W + 1;
    localparam int SUM_W    = IDX_W + 1;
    localparam int GRAN_LG  = $clog2(GRANULE_BYTES);
    localparam int DIV_IN_W = ffha_pkg::SIZE_W + 1;
    localparam int NEED_MAX = ((1 << ffha_pkg::SIZE_W) - 1 + GRANULE_BYTES - 1)
                              / GRANULE_BYTES;
    localparam int NEED_W   = $clog2(NEED_MAX + 1);
    localparam int CMP_W    = ((NEED_W > SUM_W) ? NEED_W : SUM_W) + 2;
    // reciprocal multiply: exact floor division for any dividend below 2^DIV_IN_W
    localparam int RCP_S    = DIV_IN_W + GRAN_LG;
    localparam int RCP_W    = RCP_S - GRAN_LG + 2;
    localparam int PROD_W   = DIV_IN_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((1 << RCP_S) + GRANULE_BYTES - 1) / GRANULE_BYTES);
    localparam int AP_W     = SUM_W + GRAN_LG + ffha_pkg::ADDR_W;
    localparam logic [HDR_W-1:0] HDR_RST = {IDX_W'(NGRAN - 1), 1'b1};

    // header memory
    logic [HDR_W-1:0] hdr_mem [NGRAN];
    logic [HDR_W-1:0] rd_reg;
    logic             rd_rst_reg;
    logic             e0_wr_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [HDR_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // walk and request registers
    logic [NEED_W-1:0]          q_reg;
    logic                       off_zero_reg;
    logic [IDX_W-1:0]           cur_reg;
    logic [IDX_W-1:0]           nxt_reg;
    logic [IDX_W-1:0]           hi_sz_reg;
    logic                       hi_fr_reg;
    logic [IDX_W-1:0]           keep_sz_reg;
    logic [ffha_pkg::ADDR_W-1:0] res_addr_reg;
    logic                       res_ok_reg;
    logic [ffha_pkg::ADDR_W-1:0] out_addr_reg;
    logic                       out_ok_reg;

    // combinational
    logic [ffha_pkg::SIZE_W-1:0] bytes;
    logic [DIV_IN_W-1:0]         div_in;
    logic [PROD_W-1:0]           div_prod;
    logic [NEED_W-1:0]           div_q;
    logic [HDR_W-1:0]            hdr;
    logic [IDX_W-1:0]            hdr_sz;
    logic                        hdr_fr;
    logic [CMP_W-1:0]            need_ext;
    logic [CMP_W-1:0]            sz_ext;
    logic                        fit;
    logic                        split;
    logic [CMP_W-1:0]            split_idx;
    logic [CMP_W-1:0]            split_sz;
    logic [SUM_W-1:0]            a_sum;
    logic                        a_end;
    logic                        merge;
    logic [IDX_W-1:0]            m_new_sz;
    logic [SUM_W-1:0]            m_merge_sum;
    logic [SUM_W-1:0]            m_step_sum;
    logic                        m_merge_end;
    logic                        m_step_end;
    logic [NEED_W-1:0]           q_m1;
    logic [IDX_W-1:0]            g_idx;
    logic [AP_W-1:0]             addr_prod;

    // bytes -> granules (rounded up) for allocate, offset -> granule for free
    assign bytes    = (request_size == '0) ? ffha_pkg::SIZE_W'(1) : request_size;
    assign div_in   = action ? DIV_IN_W'(payload_offset)
                             : DIV_IN_W'(bytes) + DIV_IN_W'(GRANULE_BYTES - 1);
    assign div_prod = PROD_W'(div_in) * PROD_W'(RCP_M);
    assign div_q    = div_prod[RCP_S +: NEED_W];

    // entry 0 reads as the initial free block until first written
    assign hdr    = rd_rst_reg ? HDR_RST : rd_reg;
    assign hdr_sz = hdr[HDR_W-1:1];
    assign hdr_fr = hdr[0];

    assign need_ext  = CMP_W'(q_reg);
    assign sz_ext    = CMP_W'(hdr_sz);
    assign fit       = hdr_fr && (sz_ext >= need_ext);
    assign split     = (sz_ext >= need_ext + CMP_W'(2));
    assign split_idx = CMP_W'(cur_reg) + need_ext + CMP_W'(1);
    assign split_sz  = sz_ext - need_ext - CMP_W'(1);

    assign a_sum = SUM_W'(cur_reg) + SUM_W'(hdr_sz) + SUM_W'(1);
    assign a_end = (a_sum >= SUM_W'(NGRAN));

    assign merge       = hi_fr_reg && hdr_fr;
    assign m_new_sz    = IDX_W'(SUM_W'(hi_sz_reg) + SUM_W'(hdr_sz) + SUM_W'(1));
    assign m_merge_sum = SUM_W'(cur_reg) + SUM_W'(m_new_sz) + SUM_W'(1);
    assign m_step_sum  = SUM_W'(nxt_reg) + SUM_W'(hdr_sz) + SUM_W'(1);
    assign m_merge_end = (m_merge_sum >= SUM_W'(NGRAN));
    assign m_step_end  = (m_step_sum >= SUM_W'(NGRAN));

    assign q_m1  = q_reg - NEED_W'(1);
    assign g_idx = IDX_W'(q_m1);

    assign addr_prod = (AP_W'(cur_reg) + AP_W'(1)) * AP_W'(GRANULE_BYTES);

    always_comb
    begin
        stat.fit      = fit;
        stat.off_zero = off_zero_reg;
        stat.g_ok     = (q_reg != '0) && (CMP_W'(q_reg) <= CMP_W'(NGRAN));
        case (op)
            ffha_pkg::OP_A_EVAL,
            ffha_pkg::OP_M_LOAD: stat.at_end = a_end;
            ffha_pkg::OP_M_EVAL: stat.at_end = merge ? m_merge_end : m_step_end;
            default:             stat.at_end = 1'b0;
        endcase
    end

    // memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (op)
            ffha_pkg::OP_A_START,
            ffha_pkg::OP_M_START:
            begin
                rd_en = 1'b1;
            end
            ffha_pkg::OP_A_EVAL:
            begin
                if (fit)
                begin
                    // remainder becomes a new free block
                    if (split)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(split_idx);
                        wr_data = {IDX_W'(split_sz), 1'b1};
                    end
                end
                else if (!a_end)
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(a_sum);
                end
            end
            ffha_pkg::OP_A_WRHDR:
            begin
                wr_en   = 1'b1;
                wr_data = {keep_sz_reg, 1'b0};
            end
            ffha_pkg::OP_F_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = g_idx;
            end
            ffha_pkg::OP_F_MARK:
            begin
                wr_en   = 1'b1;
                wr_addr = g_idx;
                wr_data = {hdr_sz, 1'b1};
            end
            ffha_pkg::OP_M_LOAD:
            begin
                if (!a_end)
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(a_sum);
                end
            end
            ffha_pkg::OP_M_EVAL:
            begin
                if (merge)
                begin
                    wr_en   = 1'b1;
                    wr_data = {m_new_sz, 1'b1};
                    if (!m_merge_end)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(m_merge_sum);
                    end
                end
                else if (!m_step_end)
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(m_step_sum);
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= hdr_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_rst_reg <= 1'b0;
            e0_wr_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_rst_reg <= (rd_addr == '0) && !e0_wr_reg;
            end
            if (wr_en && (wr_addr == '0))
            begin
                e0_wr_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            ffha_pkg::OP_ACCEPT:
            begin
                q_reg        <= div_q;
                off_zero_reg <= (payload_offset == '0);
                res_addr_reg <= '0;
                res_ok_reg   <= 1'b0;
            end
            ffha_pkg::OP_A_START,
            ffha_pkg::OP_M_START:
            begin
                cur_reg <= '0;
            end
            ffha_pkg::OP_A_EVAL:
            begin
                if (fit)
                begin
                    keep_sz_reg  <= split ? IDX_W'(q_reg) : hdr_sz;
                    res_addr_reg <= addr_prod[ffha_pkg::ADDR_W-1:0];
                    res_ok_reg   <= 1'b1;
                end
                else
                begin
                    cur_reg <= IDX_W'(a_sum);
                end
            end
            ffha_pkg::OP_M_LOAD:
            begin
                hi_sz_reg <= hdr_sz;
                hi_fr_reg <= hdr_fr;
                nxt_reg   <= IDX_W'(a_sum);
            end
            ffha_pkg::OP_M_EVAL:
            begin
                if (merge)
                begin
                    hi_sz_reg <= m_new_sz;
                    nxt_reg   <= IDX_W'(m_merge_sum);
                end
                else
                begin
                    cur_reg   <= nxt_reg;
                    hi_sz_reg <= hdr_sz;
                    hi_fr_reg <= hdr_fr;
                    nxt_reg   <= IDX_W'(m_step_sum);
                end
            end
            ffha_pkg::OP_OUT_LOAD:
            begin
                out_addr_reg <= res_addr_reg;
                out_ok_reg   <= res_ok_reg;
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign address = out_addr_reg;
    assign granted = out_ok_reg;

    a_merge_walk_advances: assert property (@(posedge clk) disable iff (!rst_n)
        op == ffha_pkg::OP_M_EVAL && !stat.at_end |=> nxt_reg > $past(nxt_reg))
        else $error("merge walk did not move forward");

    a_fit_grants: assert property (@(posedge clk) disable iff (!rst_n)
        op == ffha_pkg::OP_A_EVAL && fit |=> res_ok_reg)
        else $error("fitting block found but no grant recorded");

endmodule

>>> test/first_fit_heap_allocator_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// first_fit_heap_allocator_unit_tb
// Self-checking bench for the first-fit heap allocator. A mirror of the block
// header list predicts the grant for every accepted word. The bench covers
// directed corner cases, a fill-and-scatter pass, random alloc/free traffic
// with random idles on both sides, and a long output hold-off.
// ============================================================================
module first_fit_heap_allocator_unit_tb;

    localparam int ADDR_W         = ffha_pkg::ADDR_W;
    localparam int SIZE_W         = ffha_pkg::SIZE_W;
    localparam int OFFS_W         = ffha_pkg::OFFS_W;
    localparam int GRAN_BYTES     = ffha_pkg::GRANULE_BYTES_DEF;
    localparam int GRAN_N         = ffha_pkg::ARENA_BYTES_DEF
                                    / ffha_pkg::GRANULE_BYTES_DEF;
    localparam int LEN_W          = $clog2(GRAN_N);
    localparam int MAX_BYTES      = (GRAN_N - 1) * GRAN_BYTES;
    localparam int STALL_MAX      = 11;
    localparam int HOLD_OFF       = 600;
    localparam int RANDOM_ITEMS   = 880;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             free;
    } blk_hdr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              granted;
    } grant_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              action;
    logic [SIZE_W-1:0] request_size;
    logic [OFFS_W-1:0] payload_offset;
    logic              out_valid;
    logic              out_ready;
    logic [ADDR_W-1:0] address;
    logic              granted;

    // mirror of the header memory; hdr_written marks entries the block has stored
    blk_hdr_t heap_hdr [GRAN_N];
    bit       hdr_written [GRAN_N];
    grant_t   pending_grants [$];
    grant_t   last_grant;
    int       live_offs [$];
    int       mismatch_cnt;
    bit       tx_calm;
    bit       rx_calm;
    int       rx_hold;

    first_fit_heap_allocator_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .request_size   (request_size),
        .payload_offset (payload_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .address        (address),
        .granted        (granted)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // heap mirror
    // ------------------------------------------------------------------------
    function automatic void heap_reset();
        for (int k = 0; k < GRAN_N; k++)
        begin
            heap_hdr[k]    = '0;
            hdr_written[k] = 1'b0;
        end
        heap_hdr[0].len  = LEN_W'(GRAN_N - 1);
        heap_hdr[0].free = 1'b1;
        hdr_written[0]   = 1'b1;
    endfunction

    function automatic int next_blk(int i);
        int n;
        n = i + 1 + int'(heap_hdr[i].len);
        return (n < GRAN_N) ? n : GRAN_N;
    endfunction

    function automatic void coalesce_free_runs();
        int i;
        int n;
        i = 0;
        while (i < GRAN_N)
        begin
            while (heap_hdr[i].free)
            begin
                n = next_blk(i);
                if (n >= GRAN_N || !heap_hdr[n].free)
                    break;
                heap_hdr[i].len = LEN_W'(int'(heap_hdr[i].len) + 1
                                         + int'(heap_hdr[n].len));
            end
            i = next_blk(i);
        end
    endfunction

    function automatic grant_t heap_grant(logic act, logic [SIZE_W-1:0] bytes,
                                          logic [OFFS_W-1:0] off);
        grant_t g;
        int     need;
        int     i;
        int     len;
        int     gi;
        g = '0;
        if (act == ACT_ALLOC)
        begin
            need = (bytes == '0) ? 1 : (int'(bytes) + GRAN_BYTES - 1) / GRAN_BYTES;
            i = 0;
            while (i < GRAN_N)
            begin
                len = int'(heap_hdr[i].len);
                if (heap_hdr[i].free && len >= need)
                begin
                    // split only when the tail can hold a header plus one granule
                    if (len >= need + 2)
                    begin
                        heap_hdr[i + 1 + need].len  = LEN_W'(len - need - 1);
                        heap_hdr[i + 1 + need].free = 1'b1;
                        hdr_written[i + 1 + need]   = 1'b1;
                        len = need;
                    end
                    heap_hdr[i].len  = LEN_W'(len);
                    heap_hdr[i].free = 1'b0;
                    g.address = ADDR_W'((i + 1) * GRAN_BYTES);
                    g.granted = 1'b1;
                    break;
                end
                i = next_blk(i);
            end
        end
        else if (off != '0)
        begin
            gi = int'(off) / GRAN_BYTES;
            if (gi >= 1)
                heap_hdr[gi - 1].free = 1'b1;
            coalesce_free_runs();
        end
        return g;
    endfunction

    function automatic void scan_live();
        int i;
        live_offs.delete();
        i = 0;
        while (i < GRAN_N)
        begin
            if (!heap_hdr[i].free)
                live_offs.push_back((i + 1) * GRAN_BYTES);
            i = next_blk(i);
        end
    endfunction

    // an offset below one granule or one whose header slot has been stored before; never an unwritten one
    function automatic logic [OFFS_W-1:0] pick_stray_offset();
        logic [OFFS_W-1:0] off;
        repeat (64)
        begin
            off = OFFS_W'($urandom);
            if (int'(off) < GRAN_BYTES || hdr_written[int'(off) / GRAN_BYTES - 1])
                return off;
        end
        off = OFFS_W'($urandom_range(1, GRAN_BYTES - 1));
        return off;
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 3)
            return '0;
        if (pick < 65)
            return SIZE_W'($urandom_range(1, 64));
        if (pick < 88)
            return SIZE_W'($urandom_range(65, 640));
        if (pick < 96)
            return SIZE_W'($urandom_range(641, MAX_BYTES + GRAN_BYTES));
        return SIZE_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("ERROR %0t: %s", $time, what);
    endtask

    task automatic send_word(input logic act, input logic [SIZE_W-1:0] bytes,
                             input logic [OFFS_W-1:0] off);
        int gap;
        gap = tx_calm ? 0 : int'($urandom_range(0, STALL_MAX));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        request_size   <= bytes;
        payload_offset <= off;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        last_grant = heap_grant(act, bytes, off);
        pending_grants.push_back(last_grant);
    endtask

    // unused field carries random junk
    task automatic send_alloc(input logic [SIZE_W-1:0] bytes);
        logic [OFFS_W-1:0] junk;
        junk = OFFS_W'($urandom);
        send_word(ACT_ALLOC, bytes, junk);
    endtask

    task automatic send_free(input logic [OFFS_W-1:0] off);
        logic [SIZE_W-1:0] junk;
        junk = SIZE_W'($urandom);
        send_word(ACT_FREE, junk, off);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_check
        int     stall;
        grant_t got;
        grant_t want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            else
            begin
                stall = rx_calm ? 0 : int'($urandom_range(0, STALL_MAX));
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (out_valid !== 1'b1);
            got.address = address;
            got.granted = granted;
            if (pending_grants.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word address=%0d granted=%b",
                                          got.address, got.granted));
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got.address !== want.address)
                    report_mismatch($sformatf("address got %0d want %0d",
                                              got.address, want.address));
                if (got.granted !== want.granted)
                    report_mismatch($sformatf("granted got %b want %b",
                                              got.granted, want.granted));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("first_fit_heap_allocator_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        send_alloc(SIZE_W'(0));                        // zero bytes -> one granule
        send_alloc(SIZE_W'(16));
        send_alloc(SIZE_W'(17));                       // rounds up to two granules
        send_alloc(16'hFFFF);                          // oversize
        send_alloc(SIZE_W'(MAX_BYTES + 1));            // one granule too many
        send_free(OFFS_W'(0));                         // null free
        send_free(OFFS_W'(7));                         // below one granule
        send_free(OFFS_W'(53));                        // unaligned, lands on the 48 block
        send_alloc(SIZE_W'(16));                       // exact fit into the hole
        send_free(OFFS_W'(16));
        send_free(OFFS_W'(48));                        // merges with the block before
        send_alloc(SIZE_W'(33));
        send_free(OFFS_W'(16));
        send_alloc(SIZE_W'(32));                       // one granule left over, no split
        send_free(OFFS_W'(48));                        // stale header inside a live payload
        send_alloc(SIZE_W'(16));
        send_free(OFFS_W'(16));
        send_free(OFFS_W'(80));
        send_free(OFFS_W'(128));                       // whole arena back to one block
        send_alloc(SIZE_W'(MAX_BYTES));                // takes the entire arena
        send_alloc(SIZE_W'(1));                        // nothing left
        send_free(OFFS_W'(16));
        send_alloc(SIZE_W'(MAX_BYTES - GRAN_BYTES));
        send_free(OFFS_W'(16));
    endtask

    task automatic test_fill_and_scatter();
        int k;
        do
        begin
            send_alloc(SIZE_W'($urandom_range(0, GRAN_BYTES)));
        end
        while (last_grant.granted);
        scan_live();
        while (live_offs.size() > 0)
        begin
            k = int'($urandom_range(0, live_offs.size() - 1));
            send_free(OFFS_W'(live_offs[k]));
            live_offs.delete(k);
        end
    endtask

    task automatic test_random_traffic();
        int pick;
        int k;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            scan_live();
            pick = int'($urandom_range(0, 99));
            if (live_offs.size() == 0 || pick < (live_offs.size() > 24 ? 35 : 60))
            begin
                send_alloc(random_size());
            end
            else
            begin
                pick = int'($urandom_range(0, 99));
                k    = int'($urandom_range(0, live_offs.size() - 1));
                if (pick < 75)
                    send_free(OFFS_W'(live_offs[k]));
                else if (pick < 87)
                    send_free(OFFS_W'(live_offs[k]
                                      + int'($urandom_range(1, GRAN_BYTES - 1))));
                else if (pick < 91)
                    send_free(OFFS_W'(0));
                else if (pick < 95)
                    send_free(OFFS_W'($urandom_range(1, GRAN_BYTES - 1)));
                else
                    send_free(pick_stray_offset());
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // receiver parks for a long stretch; sender keeps offering until in_ready drops
    task automatic test_output_backpressure();
        rx_hold = HOLD_OFF;
        tx_calm = 1'b1;
        for (int n = 0; n < 12; n++)
        begin
            scan_live();
            if (n % 3 == 2 && live_offs.size() > 0)
                send_free(OFFS_W'(live_offs[$urandom_range(0, live_offs.size() - 1)]));
            else
                send_alloc(SIZE_W'($urandom_range(1, 200)));
        end
        tx_calm = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_ALLOC;
        request_size   = '0;
        payload_offset = '0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        rx_hold        = 0;
        mismatch_cnt   = 0;
        heap_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fill_and_scatter();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("first_fit_heap_allocator_unit: match");
        else
            $display("first_fit_heap_allocator_unit: mismatch");
        $finish;
    end

endmodule
